@@ rtl/safs_pkg.sv @@
// Shared types and constants for the sprite animation frame sequencer.
// Used by safs_ctrl, safs_dp and the top level; depends on nothing.
package safs_pkg;

    localparam int TICK_W        = 32;
    localparam int FPS_W         = 24;
    localparam int ACC_W         = 31;
    localparam int FRAME_W       = 16;
    localparam int SLOT_W        = 5;
    localparam int CMD_W         = 3;
    localparam int FRAC_BITS     = 16;
    localparam int WHOLE_W       = ACC_W - FRAC_BITS;
    localparam int PROD_W        = TICK_W + FPS_W;
    localparam int TICKS_PER_SEC = 60;
    localparam int REM60_W       = 6;
    localparam int DIGIT_W       = 4;
    localparam int DIV_STEPS     = PROD_W / DIGIT_W;
    localparam int SPAN_W        = FRAME_W + 1;
    localparam int MOD_DIGIT_W   = 2;
    localparam int MOD_IN_W      = WHOLE_W + 1;
    localparam int MOD_STEPS     = MOD_IN_W / MOD_DIGIT_W;
    localparam int CNT_W         = 4;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOOP  = 3'd0,
        CMD_ONCE  = 3'd1,
        CMD_PING  = 3'd2,
        CMD_RESET = 3'd3,
        CMD_DONE  = 3'd4
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_MUL,
        ST_DIV,
        ST_ACC,
        ST_MOD,
        ST_FIN
    } t_state;

    // Commands from the controller to the datapath, one per step.
    typedef struct packed {
        logic load;
        logic rd;
        logic mul;
        logic div;
        logic acc;
        logic mod;
        logic fin;
    } t_dp_cmd;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic adv;
    } t_dp_stat;

endpackage

@@ rtl/safs_ctrl.sv @@
// Sequencing state machine of the sprite animation frame sequencer.
// Depends on safs_pkg; drives safs_dp through t_dp_cmd.
module safs_ctrl import safs_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  t_dp_stat i_stat,
    output logic     o_busy,
    output t_dp_cmd  o_cmd
);

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_READ;
                end
            end
            ST_READ: begin
                o_cmd.rd = 1'b1;
                n_cnt    = '0;
                n_state  = i_stat.adv ? ST_MUL : ST_MOD;
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_cnt     = '0;
                n_state   = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div = 1'b1;
                n_cnt     = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_state = ST_ACC;
                end
            end
            ST_ACC: begin
                o_cmd.acc = 1'b1;
                n_cnt     = '0;
                n_state   = ST_MOD;
            end
            ST_MOD: begin
                o_cmd.mod = 1'b1;
                n_cnt     = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(MOD_STEPS - 1)) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                o_cmd.fin = 1'b1;
                n_state   = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != ST_IDLE);

`ifndef SYNTHESIS
    a_start_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && r_state == ST_IDLE) |=> r_state == ST_READ)
        else $error("accepted item did not enter the read step");

    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_DIV |-> r_cnt < CNT_W'(DIV_STEPS))
        else $error("divide step counter ran past its length");

    a_mod_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MOD && $past(r_state) != ST_MOD) |->
        ($past(r_state) == ST_ACC || $past(r_state) == ST_READ))
        else $error("modulo step entered from an unexpected state");
`endif

endmodule

@@ rtl/safs_dp.sv @@
// Datapath of the sprite animation frame sequencer: slot store, multiplier,
// divide-by-60 and modulo units, frame mapping. Depends on safs_pkg.
module safs_dp import safs_pkg::*; #(
    parameter int SLOT_COUNT = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_cmd            i_cmd,
    output t_dp_stat           o_stat,
    input  logic [CMD_W-1:0]   i_item_cmd,
    input  logic [SLOT_W-1:0]  i_slot,
    input  logic [FRAME_W-1:0] i_first_frame,
    input  logic [FRAME_W-1:0] i_last_frame,
    input  logic [FPS_W-1:0]   i_rate_fps,
    input  logic [TICK_W-1:0]  i_now_tick,
    output logic [FRAME_W-1:0] o_frame_index,
    output logic               o_done_flag,
    output logic               o_strobe
);

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    typedef struct packed {
        logic [TICK_W-1:0] prev_tick;
        logic [ACC_W-1:0]  accum;
    } t_slot_word;

    // Captured item.
    logic [CMD_W-1:0]   r_cmd;
    logic [SLOT_W-1:0]  r_slot;
    logic [FRAME_W-1:0] r_lo, r_hi;
    logic [FPS_W-1:0]   r_fps;
    logic [TICK_W-1:0]  r_now;

    t_slot_word         mem [SLOT_COUNT];
    t_slot_word         r_rd;
    logic [SLOT_COUNT-1:0] r_seeded, r_finished;

    logic [PROD_W-1:0]  r_prod;
    logic [PROD_W-1:0]  r_quot;
    logic [REM60_W-1:0] r_rem;
    logic [ACC_W-1:0]   r_base;
    logic [WHOLE_W-1:0] r_n;
    logic [MOD_IN_W-1:0] r_mn;
    logic [SPAN_W-1:0]  r_mrem;

    logic [FRAME_W-1:0] r_frame;
    logic               r_done;
    logic               r_strobe;

    logic               ok;
    logic [IDX_W-1:0]   idx;
    logic               seeded_cur;
    logic [FRAME_W-1:0] span_m1;
    logic [SPAN_W-1:0]  span, period, mod_d;
    logic [TICK_W-1:0]  elapsed;
    logic [9:0]         dv_x, dv_sub;
    logic [DIGIT_W-1:0] dv_dig;
    logic [TICK_W-1:0]  acc_sum;
    logic [ACC_W-1:0]   acc_new;
    logic [SPAN_W+1:0]  md_x, md_d1, md_d2, md_d3, md_sub;
    logic               once_end;
    logic [FRAME_W-1:0] frame_next;
    logic               done_next;

    assign ok         = (32'(r_slot) < SLOT_COUNT);
    assign idx        = IDX_W'(r_slot);
    assign seeded_cur = ok && r_seeded[idx];
    assign span_m1    = r_hi - r_lo;
    assign span       = {1'b0, span_m1} + 1'b1;
    assign period     = {span_m1, 1'b0};
    assign mod_d      = (r_cmd == CMD_PING) ? period : span;

    always_comb begin
        o_stat.adv = 1'b0;
        case (r_cmd)
            CMD_LOOP, CMD_ONCE: o_stat.adv = ok;
            CMD_PING:           o_stat.adv = ok && (span_m1 != '0);
            default:            o_stat.adv = 1'b0;
        endcase
    end

    // Item capture; a reversed range is stored swapped.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd  <= i_item_cmd;
            r_slot <= i_slot;
            r_fps  <= i_rate_fps;
            r_now  <= i_now_tick;
            if (i_last_frame < i_first_frame) begin
                r_lo <= i_last_frame;
                r_hi <= i_first_frame;
            end else begin
                r_lo <= i_first_frame;
                r_hi <= i_last_frame;
            end
        end
    end

    // Slot store: one read port and one write port, read data registered.
    always_ff @(posedge i_clk) begin
        if (i_cmd.acc) begin
            mem[idx] <= '{prev_tick: r_now, accum: acc_new};
        end
        if (i_cmd.rd) begin
            r_rd <= mem[idx];
        end
    end

    assign elapsed = seeded_cur ? (r_now - r_rd.prev_tick) : '0;

    // One radix-16 digit of the divide by 60 per step.
    always_comb begin
        dv_x   = {r_rem, r_prod[PROD_W-1 -: DIGIT_W]};
        dv_dig = '0;
        for (int k = 1; k < 16; k++) begin
            if (dv_x >= 10'(k * TICKS_PER_SEC)) begin
                dv_dig = DIGIT_W'(k);
            end
        end
        dv_sub = 10'(dv_dig) * 10'(TICKS_PER_SEC);
    end

    // Accumulate with saturation at the all-ones maximum of the accumulator.
    assign acc_sum = {1'b0, r_base} + r_quot[TICK_W-1:0];
    assign acc_new = ((|r_quot[PROD_W-1:ACC_W]) || acc_sum[TICK_W-1]) ?
                     {ACC_W{1'b1}} : acc_sum[ACC_W-1:0];

    // One radix-4 digit of the modulo by span or period per step.
    always_comb begin
        md_x  = {r_mrem, r_mn[MOD_IN_W-1 -: MOD_DIGIT_W]};
        md_d1 = {2'b00, mod_d};
        md_d2 = {1'b0, mod_d, 1'b0};
        md_d3 = md_d1 + md_d2;
        if (md_x >= md_d3) begin
            md_sub = md_d3;
        end else if (md_x >= md_d2) begin
            md_sub = md_d2;
        end else if (md_x >= md_d1) begin
            md_sub = md_d1;
        end else begin
            md_sub = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_n    <= '0;
            r_mn   <= '0;
            r_mrem <= '0;
        end
        if (i_cmd.mul) begin
            r_prod <= PROD_W'(elapsed) * PROD_W'(r_fps);
            r_base <= seeded_cur ? r_rd.accum : '0;
            r_rem  <= '0;
            r_quot <= '0;
        end
        if (i_cmd.div) begin
            r_rem  <= REM60_W'(dv_x - dv_sub);
            r_quot <= {r_quot[PROD_W-DIGIT_W-1:0], dv_dig};
            r_prod <= r_prod << DIGIT_W;
        end
        if (i_cmd.acc) begin
            r_n    <= acc_new[ACC_W-1:FRAC_BITS];
            r_mn   <= {1'b0, acc_new[ACC_W-1:FRAC_BITS]};
            r_mrem <= '0;
        end
        if (i_cmd.mod) begin
            r_mrem <= SPAN_W'(md_x - md_sub);
            r_mn   <= r_mn << MOD_DIGIT_W;
        end
    end

    assign once_end = ({1'b0, r_n} >= span_m1);

    always_comb begin
        frame_next = '0;
        done_next  = 1'b0;
        case (r_cmd)
            CMD_LOOP: begin
                frame_next = r_lo + r_mrem[FRAME_W-1:0];
                done_next  = ok && r_finished[idx];
            end
            CMD_ONCE: begin
                frame_next = once_end ? r_hi : (r_lo + FRAME_W'(r_n));
                done_next  = ok && (r_finished[idx] || once_end);
            end
            CMD_PING: begin
                if (span_m1 == '0) begin
                    frame_next = r_lo;
                end else if (r_mrem >= span) begin
                    frame_next = r_lo + FRAME_W'(period - r_mrem);
                end else begin
                    frame_next = r_lo + r_mrem[FRAME_W-1:0];
                end
                done_next = ok && r_finished[idx];
            end
            CMD_RESET: begin
                done_next = 1'b0;
            end
            CMD_DONE: begin
                done_next = ok && r_finished[idx];
            end
            default: begin
                done_next = 1'b0;
            end
        endcase
    end

    // Per-slot flags, cleared at reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seeded   <= '0;
            r_finished <= '0;
        end else begin
            if (i_cmd.acc) begin
                r_seeded[idx] <= 1'b1;
                if (!seeded_cur) begin
                    r_finished[idx] <= 1'b0;
                end
            end
            if (i_cmd.fin && ok) begin
                if (r_cmd == CMD_RESET) begin
                    r_seeded[idx]   <= 1'b0;
                    r_finished[idx] <= 1'b0;
                end else if (r_cmd == CMD_ONCE && once_end) begin
                    r_finished[idx] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fin) begin
            r_frame <= frame_next;
            r_done  <= done_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.fin;
        end
    end

    assign o_frame_index = r_frame;
    assign o_done_flag   = r_done;
    assign o_strobe      = r_strobe;

`ifndef SYNTHESIS
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |=> !r_strobe)
        else $error("result strobe held for more than one cycle");

    a_rem60_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div |-> r_rem < REM60_W'(TICKS_PER_SEC))
        else $error("divide-by-60 remainder out of range");

    a_reset_no_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && r_cmd == CMD_RESET) |-> !r_done)
        else $error("slot reset reported a done flag");
`endif

endmodule

@@ rtl/sprite_animation_frame_sequencer.sv @@
// Top level of the sprite animation frame sequencer.
// Depends on safs_pkg, safs_ctrl and safs_dp.
//
// Usage: present an item on the i_ ports with start high; it is taken at a
// rising edge where busy is low. Each item names a slot and a command (loop,
// once or ping-pong query, slot reset, done read). Exactly one result comes
// back per item: o_frame_index and o_done_flag are valid for the single
// cycle in which o_strobe is high. The receiver cannot hold a result off,
// so it must capture it in that cycle.
//
// Sequence: a query that advances its slot is answered after the read,
// multiply, 14 radix-16 divide-by-60 steps, accumulate, 8 radix-4 modulo
// steps and result. Other items go through the read, the modulo steps and
// the result. busy drops in the cycle that shows the result, so the next
// item can be taken there, but not while busy is high. The iterative divide
// by 60 and the modulo by the frame span set the length of an item.
//
// Reset (synchronous, active low) clears every slot's seeded and finished
// flag at once; the tick and accumulator store needs no clearing because
// an unseeded slot never reads it. No clearing pass is needed.
module sprite_animation_frame_sequencer import safs_pkg::*; #(
    parameter int SLOT_COUNT = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [CMD_W-1:0]   i_cmd,
    input  logic [SLOT_W-1:0]  i_slot,
    input  logic [FRAME_W-1:0] i_first_frame,
    input  logic [FRAME_W-1:0] i_last_frame,
    input  logic [FPS_W-1:0]   i_rate_fps,
    input  logic [TICK_W-1:0]  i_now_tick,
    output logic [FRAME_W-1:0] o_frame_index,
    output logic               o_done_flag,
    output logic               o_strobe
);

    // Commands flow from the controller; the datapath answers with whether
    // the captured item advances a slot's accumulator.
    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    safs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (dp_stat),
        .o_busy  (busy),
        .o_cmd   (dp_cmd)
    );

    safs_dp #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .o_stat        (dp_stat),
        .i_item_cmd    (i_cmd),
        .i_slot        (i_slot),
        .i_first_frame (i_first_frame),
        .i_last_frame  (i_last_frame),
        .i_rate_fps    (i_rate_fps),
        .i_now_tick    (i_now_tick),
        .o_frame_index (o_frame_index),
        .o_done_flag   (o_done_flag),
        .o_strobe      (o_strobe)
    );

endmodule

@@ sim/sprite_animation_frame_sequencer_test.sv @@
// Self-checking testbench for the sprite animation frame sequencer.
// Depends on safs_pkg and the sprite_animation_frame_sequencer top level only.
`timescale 1ns / 100ps

module sprite_animation_frame_sequencer_test;
    import safs_pkg::*;

    localparam int SLOTS         = 32;
    localparam int CMD_CODES     = 1 << CMD_W;
    localparam int RANDOM_ITEMS  = 1525;
    localparam int STALL_LIMIT   = 2000;
    localparam int DRAIN_CYCLES  = 40;
    localparam int REPORT_LIMIT  = 10;
    localparam logic [FPS_W-1:0] FPS_SIXTY = 24'h3C_0000;
    localparam logic [FPS_W-1:0] FPS_MAX   = 24'hFF_FFFF;
    localparam logic [63:0] ACC_LIMIT = (64'd1 << ACC_W) - 64'd1;

    // One predicted result, tagged with the item that caused it.
    typedef struct {
        int unsigned        seq;
        logic [CMD_W-1:0]   cmd;
        logic [SLOT_W-1:0]  slot;
        logic [FRAME_W-1:0] frame;
        logic               done;
    } t_frame_result;

    // Scoreboard: keeps its own copy of every animator slot, predicts the
    // result of each accepted item and checks results in order.
    class t_frame_scoreboard;
        logic [TICK_W-1:0] tick_seen [SLOTS];
        logic [ACC_W-1:0]  accum [SLOTS];
        bit                seeded [SLOTS];
        bit                finished [SLOTS];
        t_frame_result     expected_frames [$];
        int unsigned       items_noted;
        int unsigned       mismatches;

        function new();
            foreach (seeded[s]) begin
                tick_seen[s] = '0;
                accum[s]     = '0;
                seeded[s]    = 1'b0;
                finished[s]  = 1'b0;
            end
            items_noted = 0;
            mismatches  = 0;
        endfunction

        // Moves a slot forward to the given tick and returns the whole
        // number of animation frames it has accumulated since seeding.
        function int unsigned advance_slot(int unsigned s, bit ok,
                                           logic [FPS_W-1:0] fps,
                                           logic [TICK_W-1:0] now);
            logic [TICK_W-1:0] elapsed;
            logic [63:0]       gain;
            logic [63:0]       total;
            if (!ok)
                return 0;
            if (!seeded[s]) begin
                seeded[s]    = 1'b1;
                tick_seen[s] = now;
                accum[s]     = '0;
                finished[s]  = 1'b0;
            end
            elapsed      = now - tick_seen[s];
            tick_seen[s] = now;
            gain  = (64'(elapsed) * 64'(fps)) / 64'(TICKS_PER_SEC);
            total = 64'(accum[s]) + gain;
            accum[s] = (total > ACC_LIMIT) ? ACC_LIMIT[ACC_W-1:0] : total[ACC_W-1:0];
            return int'(accum[s]) >> FRAC_BITS;
        endfunction

        function void note_item(logic [CMD_W-1:0] cmd, logic [SLOT_W-1:0] slot,
                                logic [FRAME_W-1:0] first, logic [FRAME_W-1:0] last,
                                logic [FPS_W-1:0] fps, logic [TICK_W-1:0] now);
            t_frame_result r;
            bit            ok;
            int unsigned   s, lo, hi, span, period, phase, n;
            ok = slot < SLOTS;
            s  = ok ? slot : 0;
            // A reversed range is treated as the same range in order.
            lo   = (last < first) ? last : first;
            hi   = (last < first) ? first : last;
            span = hi - lo + 1;
            r.seq   = items_noted;
            r.cmd   = cmd;
            r.slot  = slot;
            r.frame = '0;
            r.done  = 1'b0;
            items_noted++;
            case (cmd)
                CMD_LOOP: begin
                    n = advance_slot(s, ok, fps, now);
                    r.frame = FRAME_W'(lo + n % span);
                end
                CMD_ONCE: begin
                    n = advance_slot(s, ok, fps, now);
                    if (n >= span - 1) begin
                        if (ok)
                            finished[s] = 1'b1;
                        r.frame = FRAME_W'(hi);
                    end else begin
                        r.frame = FRAME_W'(lo + n);
                    end
                end
                CMD_PING: begin
                    // A one-frame bounce has no period: the slot is left alone.
                    if (span <= 1) begin
                        r.frame = FRAME_W'(lo);
                    end else begin
                        period = 2 * span - 2;
                        n      = advance_slot(s, ok, fps, now);
                        phase  = n % period;
                        if (phase >= span)
                            phase = period - phase;
                        r.frame = FRAME_W'(lo + phase);
                    end
                end
                CMD_RESET: begin
                    if (ok) begin
                        seeded[s]   = 1'b0;
                        accum[s]    = '0;
                        finished[s] = 1'b0;
                    end
                end
                CMD_DONE: begin
                end
                default: begin
                    // Undefined commands answer zero and leave the slot alone.
                    expected_frames.push_back(r);
                    return;
                end
            endcase
            r.done = ok && finished[s];
            expected_frames.push_back(r);
        endfunction

        function void report(string what);
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("mismatch: %s", what);
        endfunction

        function void check_result(logic [FRAME_W-1:0] frame, logic done);
            t_frame_result want;
            if (expected_frames.size() == 0) begin
                report($sformatf("result with nothing pending: frame %0d done %b",
                                 frame, done));
                return;
            end
            want = expected_frames.pop_front();
            if (frame !== want.frame || done !== want.done)
                report($sformatf({"item %0d cmd %0d slot %0d: frame %0d done %b, ",
                                  "expected frame %0d done %b"},
                                 want.seq, want.cmd, want.slot, frame, done,
                                 want.frame, want.done));
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [CMD_W-1:0]   i_cmd;
    logic [SLOT_W-1:0]  i_slot;
    logic [FRAME_W-1:0] i_first_frame;
    logic [FRAME_W-1:0] i_last_frame;
    logic [FPS_W-1:0]   i_rate_fps;
    logic [TICK_W-1:0]  i_now_tick;
    logic [FRAME_W-1:0] o_frame_index;
    logic               o_done_flag;
    logic               o_strobe;

    t_frame_scoreboard  board;
    int unsigned        stall_cycles;
    bit                 calm;
    logic [TICK_W-1:0]  tick_now;
    logic [FRAME_W-1:0] range_first [SLOTS];
    logic [FRAME_W-1:0] range_last [SLOTS];

    sprite_animation_frame_sequencer #(
        .SLOT_COUNT(SLOTS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_cmd         (i_cmd),
        .i_slot        (i_slot),
        .i_first_frame (i_first_frame),
        .i_last_frame  (i_last_frame),
        .i_rate_fps    (i_rate_fps),
        .i_now_tick    (i_now_tick),
        .o_frame_index (o_frame_index),
        .o_done_flag   (o_done_flag),
        .o_strobe      (o_strobe)
    );

    always #2 i_clk = ~i_clk;

    // Results cannot be held off, so every strobe is checked at the edge
    // that ends its cycle.
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe)
            board.check_result(o_frame_index, o_done_flag);
    end

    // The watchdog restarts whenever an item or a result moves. A long
    // quiet stretch means the block has hung or lost a result.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Mostly back-to-back items, some short pauses and a few long ones.
    // During calm stretches the sender never pauses.
    function automatic int unsigned pick_gap();
        int unsigned roll;
        if (calm)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 4);
        if (roll < 97)
            return $urandom_range(5, 30);
        return $urandom_range(31, 80);
    endfunction

    // Gives a slot a fresh short frame range, sometimes stored reversed.
    function automatic void new_range(int unsigned s);
        logic [FRAME_W-1:0] base;
        logic [FRAME_W-1:0] top;
        base = FRAME_W'($urandom_range(0, 16'hFFFF - 16));
        top  = base + FRAME_W'($urandom_range(0, 11));
        if ($urandom_range(0, 1)) begin
            range_first[s] = top;
            range_last[s]  = base;
        end else begin
            range_first[s] = base;
            range_last[s]  = top;
        end
    endfunction

    // Presents one item, holds it until the block takes it, records it and
    // then pauses for a random gap with junk on the idle fields. start is
    // only lowered when a gap follows, so it never toggles within one step.
    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [SLOT_W-1:0] slot,
                             input logic [FRAME_W-1:0] first, input logic [FRAME_W-1:0] last,
                             input logic [FPS_W-1:0] fps, input logic [TICK_W-1:0] now);
        int unsigned gap;
        i_cmd         <= cmd;
        i_slot        <= slot;
        i_first_frame <= first;
        i_last_frame  <= last;
        i_rate_fps    <= fps;
        i_now_tick    <= now;
        start         <= 1'b1;
        do
            @(posedge i_clk);
        while (busy !== 1'b0);
        board.note_item(cmd, slot, first, last, fps, now);
        gap = pick_gap();
        if (gap != 0)
            start <= 1'b0;
        repeat (gap) begin
            i_cmd         <= CMD_W'($urandom);
            i_slot        <= SLOT_W'($urandom);
            i_first_frame <= FRAME_W'($urandom);
            i_last_frame  <= FRAME_W'($urandom);
            i_rate_fps    <= FPS_W'($urandom);
            i_now_tick    <= $urandom;
            @(posedge i_clk);
        end
    endtask

    // Random items mostly replay each slot's own range against a plausible
    // advancing tick, so slots run through whole animations, finish once
    // sequences and bounce. Fresh ranges, odd rates and tick jumps (which
    // wrap the counter and saturate the accumulator) are mixed in.
    task automatic random_item();
        logic [CMD_W-1:0]   cmd;
        logic [SLOT_W-1:0]  slot;
        logic [FRAME_W-1:0] first;
        logic [FRAME_W-1:0] last;
        logic [FPS_W-1:0]   fps;
        int unsigned        roll;
        roll = $urandom_range(0, 99);
        if (roll < 30)
            cmd = CMD_LOOP;
        else if (roll < 52)
            cmd = CMD_ONCE;
        else if (roll < 80)
            cmd = CMD_PING;
        else if (roll < 87)
            cmd = CMD_RESET;
        else if (roll < 97)
            cmd = CMD_DONE;
        else
            cmd = CMD_W'($urandom_range(int'(CMD_DONE) + 1, CMD_CODES - 1));

        if ($urandom_range(0, 99) < 80)
            slot = SLOT_W'($urandom_range(0, 7));
        else
            slot = SLOT_W'($urandom_range(0, SLOTS - 1));

        roll = $urandom_range(0, 99);
        if (roll < 10)
            new_range(slot);
        if (roll < 85) begin
            first = range_first[slot];
            last  = range_last[slot];
        end else begin
            first = FRAME_W'($urandom);
            last  = FRAME_W'($urandom);
        end

        roll = $urandom_range(0, 99);
        if (roll < 80)
            fps = FPS_W'($urandom_range(1 << 14, 60 << 16));
        else if (roll < 85)
            fps = '0;
        else
            fps = FPS_W'($urandom);

        roll = $urandom_range(0, 99);
        if (roll < 85)
            tick_now = tick_now + $urandom_range(0, 6);
        else if (roll < 95)
            tick_now = tick_now + $urandom_range(7, 600);
        else
            tick_now = $urandom;

        send_item(cmd, slot, first, last, fps, tick_now);
    endtask

    initial begin
        board = new();
        i_rst_n       <= 1'b0;
        start         <= 1'b0;
        i_cmd         <= CMD_LOOP;
        i_slot        <= '0;
        i_first_frame <= '0;
        i_last_frame  <= '0;
        i_rate_fps    <= '0;
        i_now_tick    <= '0;
        calm     = 1'b0;
        tick_now = TICK_W'($urandom_range(0, 1000));
        foreach (range_first[s])
            new_range(s);
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed items. A done read on a fresh slot, a loop that wraps
        // its range, a once animation that finishes and keeps its flag
        // through a later loop query until the slot is reset.
        send_item(CMD_DONE, 0, 0, 0, 0, 0);
        send_item(CMD_LOOP, 0, 0, 3, FPS_SIXTY, 100);
        send_item(CMD_LOOP, 0, 0, 3, FPS_SIXTY, 101);
        send_item(CMD_LOOP, 0, 0, 3, FPS_SIXTY, 105);
        send_item(CMD_ONCE, 1, 10, 12, FPS_SIXTY, 200);
        send_item(CMD_ONCE, 1, 10, 12, FPS_SIXTY, 203);
        send_item(CMD_DONE, 1, 0, 0, 0, 0);
        send_item(CMD_LOOP, 1, 10, 12, FPS_SIXTY, 204);
        send_item(CMD_RESET, 1, 0, 0, 0, 0);
        send_item(CMD_DONE, 1, 0, 0, 0, 0);
        // A one-frame bounce must not seed its slot; the reversed range
        // that follows seeds it and then bounces back from the top.
        send_item(CMD_PING, 2, 5, 5, FPS_SIXTY, 300);
        send_item(CMD_PING, 2, 8, 5, FPS_SIXTY, 300);
        send_item(CMD_PING, 2, 8, 5, FPS_SIXTY, 305);
        // The tick counter wraps between these two queries.
        send_item(CMD_LOOP, 3, 0, 9, FPS_SIXTY, 32'hFFFF_FFFE);
        send_item(CMD_LOOP, 3, 0, 9, FPS_SIXTY, 32'h0000_0002);
        // The largest rate over the longest interval saturates the
        // accumulator across the full frame range.
        send_item(CMD_LOOP, 4, 0, 16'hFFFF, FPS_MAX, 0);
        send_item(CMD_LOOP, 4, 0, 16'hFFFF, FPS_MAX, 32'hFFFF_FFFF);
        // A once animation of a single frame is finished at once.
        send_item(CMD_ONCE, 5, 16'hFFFF, 16'hFFFF, 0, 32'hFFFF_FFFF);
        // Undefined commands on that finished slot answer frame zero with no done flag.
        for (int c = int'(CMD_DONE) + 1; c < CMD_CODES; c++)
            send_item(CMD_W'(c), 5, 16'hFFFF, 0, FPS_MAX, 32'hFFFF_FFFF);
        send_item(CMD_PING, 31, 16'hFFFF, 0, FPS_MAX, 32'h5555_AAAA);
        send_item(CMD_PING, 31, 16'hFFFF, 0, FPS_MAX, 32'hAAAA_5555);
        send_item(CMD_ONCE, 6, 0, 16'hFFFF, 0, 7);
        send_item(CMD_RESET, 31, 0, 0, 0, 0);

        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            // Switch between calm and gappy stretches now and then.
            if (k % 128 == 0)
                calm = ($urandom_range(0, 3) == 0);
            random_item();
        end
        start <= 1'b0;

        // Let the last results arrive, then watch a little longer for any
        // stray strobe.
        while (board.expected_frames.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (board.mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
